// ===== design/ptt_pkg.sv =====
// shared types, codes and constants of the periodic timer table
package ptt_pkg;

   // default table depth
   localparam int PTT_NUM_SLOTS = 16;

   // time and word widths
   localparam int TIME_W = 48;
   localparam int WORD_W = 32;
   localparam int SLOT_FIELD_W = 4;

   // request opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOT_USED = 2'd2;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [TIME_W-1:0]       now_ms;
      logic [WORD_W-1:0]       interval_ms;
      logic [WORD_W-1:0]       user_tag;
      logic [SLOT_FIELD_W-1:0] slot_id;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [1:0]              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [WORD_W-1:0]       fired_tag;
      logic                    last;
   } rsp_type;

   // one timer entry as held in the store
   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [WORD_W-1:0] period;
      logic [WORD_W-1:0] tag;
   } entry_type;

   // store commands from the sequencer
   typedef struct packed {
      logic wr_en;
      logic set_en;
      logic clr_en;
   } store_cmd_type;

endpackage

// ===== design/ptt_alu.sv =====
// shared saturating due-time adder and due-time comparator
module ptt_alu
   import ptt_pkg::*;
(
   input  logic [TIME_W-1:0] base,
   input  logic [WORD_W-1:0] incr,
   input  logic [TIME_W-1:0] now_ms,
   output logic [TIME_W-1:0] sum_sat,
   output logic              due_reached
);

   logic [TIME_W:0] sum_wide;

   // add with saturation at the top of the time range
   always_comb begin
      sum_wide = {1'b0, base} + {{(TIME_W + 1 - WORD_W){1'b0}}, incr};
      if (sum_wide[TIME_W]) begin
         sum_sat = {TIME_W{1'b1}};
      end else begin
         sum_sat = sum_wide[TIME_W-1:0];
      end
   end

   // timer is due once now has reached its due time
   assign due_reached = (now_ms >= base);

endmodule

// ===== design/ptt_store.sv =====
// timer entry memory with registered read and per-slot valid flags
module ptt_store
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = PTT_NUM_SLOTS,
   localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   input  logic [SLOT_W-1:0]     wr_addr,
   input  entry_type             wr_data,
   input  logic [SLOT_W-1:0]     rd_addr,
   output entry_type             rd_data,
   input  logic [SLOT_W-1:0]     valid_addr,
   output logic [NUM_SLOTS-1:0]  valid_vec
);

   entry_type            mem_ff [NUM_SLOTS];
   entry_type            rd_data_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [NUM_SLOTS-1:0] valid_in;

   // entry memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // valid flag update
   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_en) begin
         valid_in[valid_addr] = 1'b1;
      end
      if (cmd.clr_en) begin
         valid_in[valid_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data   = rd_data_ff;
   assign valid_vec = valid_ff;

endmodule

// ===== design/ptt_ctrl.sv =====
// sequencer: request decode, slot scans and response register
module ptt_ctrl
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = PTT_NUM_SLOTS,
   localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   output store_cmd_type        cmd,
   output logic [SLOT_W-1:0]    wr_addr,
   output entry_type            wr_data,
   output logic [SLOT_W-1:0]    rd_addr,
   input  entry_type            rd_data,
   output logic [SLOT_W-1:0]    valid_addr,
   input  logic [NUM_SLOTS-1:0] valid_vec,
   output logic [TIME_W-1:0]    alu_base,
   output logic [WORD_W-1:0]    alu_incr,
   output logic [TIME_W-1:0]    alu_now,
   input  logic [TIME_W-1:0]    alu_sum,
   input  logic                 alu_due
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_REMOVE,
      ST_TREAD,
      ST_TEVAL,
      ST_TNEXT,
      ST_OUT
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [6:0]        SLOTS_7  = 7'(NUM_SLOTS);

   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [3:0]        idx_slot;
   logic [SLOT_W-1:0] sid_idx;
   logic              sid_ok;
   logic              hit;
   logic              fire;
   rsp_type           fire_rsp;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_slot = SLOT_FIELD_W'(idx_ff);
   assign sid_idx  = SLOT_W'(req_ff.slot_id);
   assign sid_ok   = (7'(req_ff.slot_id) < SLOTS_7);
   assign hit      = sid_ok && valid_vec[sid_idx];
   assign fire     = valid_vec[idx_ff] && alu_due;

   // fired response for the slot under evaluation
   always_comb begin
      fire_rsp.kind      = KIND_FIRED;
      fire_rsp.status    = STAT_OK;
      fire_rsp.slot      = idx_slot;
      fire_rsp.fired_tag = rd_data.tag;
      fire_rsp.last      = 1'b0;
   end

   // next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      cmd        = '0;
      wr_addr    = idx_ff;
      rd_addr    = idx_ff;
      valid_addr = idx_ff;
      alu_now    = req_ff.now_ms;
      if (state_ff == ST_ADD) begin
         alu_base = req_ff.now_ms;
         alu_incr = req_ff.interval_ms;
      end else begin
         alu_base = rd_data.due;
         alu_incr = rd_data.period;
      end
      wr_data.due    = alu_sum;
      wr_data.period = rd_data.period;
      wr_data.tag    = rd_data.tag;

      // response register drains on a taken transaction
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               case (req_data.opcode)
                  OP_ADD:    state_in = ST_ADD;
                  OP_REMOVE: state_in = ST_REMOVE;
                  OP_TICK:   state_in = ST_TREAD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end

         // search for the lowest free slot
         ST_ADD: begin
            res_in.kind      = KIND_ADD;
            res_in.fired_tag = '0;
            res_in.last      = 1'b1;
            if (!valid_vec[idx_ff]) begin
               cmd.wr_en      = 1'b1;
               cmd.set_en     = 1'b1;
               wr_data.due    = alu_sum;
               wr_data.period = req_ff.interval_ms;
               wr_data.tag    = req_ff.user_tag;
               res_in.status  = STAT_OK;
               res_in.slot    = idx_slot;
               state_in       = ST_OUT;
               ret_in         = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               res_in.status = STAT_FULL;
               res_in.slot   = '0;
               state_in      = ST_OUT;
               ret_in        = ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         ST_REMOVE: begin
            valid_addr       = sid_idx;
            cmd.clr_en       = hit;
            res_in.kind      = KIND_REMOVE;
            res_in.status    = hit ? STAT_OK : STAT_NOT_USED;
            res_in.slot      = req_ff.slot_id;
            res_in.fired_tag = '0;
            res_in.last      = 1'b1;
            state_in         = ST_OUT;
            ret_in           = ST_IDLE;
         end

         // entry read issued, data arrives next cycle
         ST_TREAD: begin
            state_in = ST_TEVAL;
         end

         // compare and advance; hold one fire back to mark the last one
         ST_TEVAL: begin
            state_in = ST_TNEXT;
            if (fire) begin
               cmd.wr_en     = 1'b1;
               pend_in       = fire_rsp;
               pend_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  res_in   = pend_ff;
                  state_in = ST_OUT;
                  ret_in   = ST_TNEXT;
               end
            end
         end

         ST_TNEXT: begin
            if (idx_ff == LAST_IDX) begin
               if (pend_valid_ff) begin
                  res_in      = pend_ff;
                  res_in.last = 1'b1;
               end else begin
                  res_in.kind      = KIND_NONE;
                  res_in.status    = STAT_OK;
                  res_in.slot      = '0;
                  res_in.fired_tag = '0;
                  res_in.last      = 1'b1;
               end
               state_in = ST_OUT;
               ret_in   = ST_IDLE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_TREAD;
            end
         end

         // hand the result to the response register
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ret_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/periodic_timer_table.sv =====
// periodic timer table, one request at a time through a small sequencer
// add: scans for the lowest free slot, then registers the response through the output state
// remove: a single check of the slot's valid flag; tick: one read, compare and step per slot
// on the shared adder/comparator; each fire after the first adds a pass through the output state
// next request accepted once the last response registers; response stalls can hold the output state
// synchronous reset clears all valid flags at once; no clearing pass
module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = PTT_NUM_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   store_cmd_type        cmd;
   logic [SLOT_W-1:0]    wr_addr;
   entry_type            wr_data;
   logic [SLOT_W-1:0]    rd_addr;
   entry_type            rd_data;
   logic [SLOT_W-1:0]    valid_addr;
   logic [NUM_SLOTS-1:0] valid_vec;
   logic [TIME_W-1:0]    alu_base;
   logic [WORD_W-1:0]    alu_incr;
   logic [TIME_W-1:0]    alu_now;
   logic [TIME_W-1:0]    alu_sum;
   logic                 alu_due;

   // sequencer
   ptt_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .valid_addr (valid_addr),
      .valid_vec  (valid_vec),
      .alu_base   (alu_base),
      .alu_incr   (alu_incr),
      .alu_now    (alu_now),
      .alu_sum    (alu_sum),
      .alu_due    (alu_due)
   );

   // timer entry store
   ptt_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .valid_addr (valid_addr),
      .valid_vec  (valid_vec)
   );

   // shared adder and comparator
   ptt_alu u_alu (
      .base        (alu_base),
      .incr        (alu_incr),
      .now_ms      (alu_now),
      .sum_sat     (alu_sum),
      .due_reached (alu_due)
   );

endmodule

// ===== test/ptt_checker.sv =====
// checker for the periodic timer table: predicts responses and compares them
`timescale 1ns / 1ps
module ptt_checker
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = PTT_NUM_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   // predicted timer store
   logic              timer_active [NUM_SLOTS];
   logic [TIME_W-1:0] due_at       [NUM_SLOTS];
   logic [WORD_W-1:0] period_ms    [NUM_SLOTS];
   logic [WORD_W-1:0] tag_of       [NUM_SLOTS];

   // responses still owed by the block, oldest first
   rsp_type expected_rsps[$];

   // due time plus period, saturating at the top of the time range
   function automatic logic [TIME_W-1:0] advance_due(input logic [TIME_W-1:0] base,
                                                     input logic [WORD_W-1:0] step);
      logic [TIME_W:0] sum;
      sum = {1'b0, base} + {{(TIME_W-WORD_W+1){1'b0}}, step};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

   function automatic string show_rsp(input rsp_type r);
      return $sformatf("kind %0d status %0d slot %0d tag %h last %0d",
                       r.kind, r.status, r.slot, r.fired_tag, r.last);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%t mismatch: %s", $realtime, msg);
   endtask

   // work out the responses of one accepted request and update the store
   task automatic predict_request(input req_type r);
      rsp_type res;
      int      free_slot;
      int      fired;
      res = '0;
      res.last = 1'b1;
      case (r.opcode)
         OP_ADD: begin
            free_slot = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
               if (free_slot < 0 && !timer_active[i])
                  free_slot = i;
            res.kind = KIND_ADD;
            if (free_slot < 0) begin
               res.status = STAT_FULL;
            end else begin
               timer_active[free_slot] = 1'b1;
               due_at[free_slot] = advance_due(r.now_ms, r.interval_ms);
               period_ms[free_slot] = r.interval_ms;
               tag_of[free_slot] = r.user_tag;
               res.status = STAT_OK;
               res.slot = SLOT_FIELD_W'(free_slot);
            end
            expected_rsps.push_back(res);
         end
         OP_REMOVE: begin
            res.kind = KIND_REMOVE;
            res.slot = r.slot_id;
            if (int'(r.slot_id) < NUM_SLOTS && timer_active[r.slot_id]) begin
               timer_active[r.slot_id] = 1'b0;
               due_at[r.slot_id] = '0;
               period_ms[r.slot_id] = '0;
               tag_of[r.slot_id] = '0;
               res.status = STAT_OK;
            end else begin
               res.status = STAT_NOT_USED;
            end
            expected_rsps.push_back(res);
         end
         OP_TICK: begin
            fired = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (timer_active[i] && r.now_ms >= due_at[i]) begin
                  due_at[i] = advance_due(due_at[i], period_ms[i]);
                  res = '0;
                  res.kind = KIND_FIRED;
                  res.slot = SLOT_FIELD_W'(i);
                  res.fired_tag = tag_of[i];
                  expected_rsps.push_back(res);
                  fired++;
               end
            end
            res = '0;
            if (fired == 0) begin
               res.kind = KIND_NONE;
            end else begin
               // the final firing closes the tick
               res = expected_rsps.pop_back();
            end
            res.last = 1'b1;
            expected_rsps.push_back(res);
         end
         default: ;
      endcase
   endtask

   // watch both channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            timer_active[i] = 1'b0;
            due_at[i] = '0;
            period_ms[i] = '0;
            tag_of[i] = '0;
         end
         expected_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               note_failure({"unexpected transaction: ", show_rsp(rsp_data)});
            end else begin
               want = expected_rsps.pop_front();
               if (want.kind != rsp_data.kind || want.status != rsp_data.status ||
                   want.slot != rsp_data.slot || want.fired_tag != rsp_data.fired_tag ||
                   want.last != rsp_data.last)
                  note_failure({"expected ", show_rsp(want), ", got ", show_rsp(rsp_data)});
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_data);
      end
      pending <= expected_rsps.size();
   end

endmodule

// ===== test/tb_periodic_timer_table.sv =====
// testbench top for the periodic timer table: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_periodic_timer_table;
   import ptt_pkg::*;

   localparam int         RUN_LIMIT    = 500000;
   localparam int         RANDOM_ITEMS = 400;
   localparam int         QUIET_ITEMS  = 60;
   localparam int         DRAIN_CYCLES = 100;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int                fail_count;
   int                pending;
   int                cycles = 0;
   int                stall_left = 0;
   bit                idle_on = 1'b1;
   logic [TIME_W-1:0] sim_now = 48'd1000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   periodic_timer_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ptt_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("[periodic_timer_table] ERROR");
         $finish;
      end
   end

   // response back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type make_item(input logic [1:0] op,
                                         input logic [TIME_W-1:0] now,
                                         input logic [WORD_W-1:0] ivl,
                                         input logic [WORD_W-1:0] tag,
                                         input logic [SLOT_FIELD_W-1:0] sid);
      req_type item;
      item.opcode = op;
      item.now_ms = now;
      item.interval_ms = ivl;
      item.user_tag = tag;
      item.slot_id = sid;
      return item;
   endfunction

   // mostly well-formed traffic on a rising time base, some wild times
   function automatic req_type random_item();
      req_type           item;
      int                pick;
      logic [15:0]       hi;
      logic [TIME_W-1:0] wild_now;
      pick = $urandom_range(0, 99);
      hi = 16'($urandom);
      wild_now = {hi, 32'($urandom)};
      item.user_tag = $urandom;
      item.slot_id = SLOT_FIELD_W'($urandom);
      item.interval_ms = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 40))
                                                    : 32'($urandom);
      item.now_ms = wild_now;
      if (pick < 4) begin
         item.opcode = OP_UNUSED;
      end else if (pick < 44) begin
         item.opcode = OP_ADD;
         if ($urandom_range(0, 19) != 0)
            item.now_ms = sim_now;
      end else if (pick < 64) begin
         item.opcode = OP_REMOVE;
      end else begin
         item.opcode = OP_TICK;
         if ($urandom_range(0, 32) != 0) begin
            sim_now = sim_now + TIME_W'(($urandom_range(0, 15) == 0)
                                        ? $urandom_range(0, 500)
                                        : $urandom_range(0, 25));
            item.now_ms = sim_now;
         end
      end
      return item;
   endfunction

   // offer one transaction, with an occasional idle burst before it
   task automatic send_item(input req_type item);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      req_type           item;
      int                done;
      logic [TIME_W-1:0] top_time;
      top_time = {TIME_W{1'b1}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table, zero interval, saturated due time
      send_item(make_item(OP_TICK, '0, '0, '0, '0));
      send_item(make_item(OP_ADD, '0, '0, 32'hFFFF_FFFF, '0));
      send_item(make_item(OP_ADD, 48'd100, 32'd10, 32'hA5A5_5A5A, '0));
      send_item(make_item(OP_ADD, top_time, 32'hFFFF_FFFF, 32'h0000_0001, 4'hF));
      send_item(make_item(OP_TICK, '0, '0, '0, '0));
      send_item(make_item(OP_TICK, 48'd110, '0, '0, '0));
      send_item(make_item(OP_TICK, top_time, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));

      // hole below the highest slot is reused
      send_item(make_item(OP_REMOVE, '0, '0, '0, 4'd1));
      send_item(make_item(OP_ADD, 48'd200, 32'd5, 32'h1234_5678, '0));

      // unused opcode is ignored
      send_item(make_item(OP_UNUSED, top_time, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));

      // fill the table, overflow it, then fire every slot at once
      for (int i = 3; i < PTT_NUM_SLOTS; i++)
         send_item(make_item(OP_ADD, sim_now, 32'($urandom_range(0, 40)), $urandom, '0));
      send_item(make_item(OP_ADD, sim_now, 32'd7, $urandom, '0));
      send_item(make_item(OP_TICK, top_time, '0, '0, '0));

      // free the highest slot, then free it again
      send_item(make_item(OP_REMOVE, '0, '0, '0, 4'hF));
      send_item(make_item(OP_REMOVE, '0, '0, '0, 4'hF));

      // random traffic, quiet towards the end
      done = 0;
      while (done < RANDOM_ITEMS) begin
         if (done == RANDOM_ITEMS - QUIET_ITEMS)
            idle_on <= 1'b0;
         item = random_item();
         send_item(item);
         if (item.opcode != OP_UNUSED)
            done++;
      end
      req_valid <= 1'b0;

      // drain, then allow for any stray transactions
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[periodic_timer_table] OK");
      else
         $display("[periodic_timer_table] ERROR");
      $finish;
   end

endmodule
